// ===== rtl/rhsv_pkg.sv =====
package rhsv_pkg;

  // number of divider cells, one quotient bit each
  localparam int unsigned NUM_CELLS = 8;
  // lanes: saturation, then the red, green and blue terms
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_SAT  = 0;
  localparam int unsigned LANE_R    = 1;
  localparam int unsigned LANE_G    = 2;
  localparam int unsigned LANE_B    = 3;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [9:0] HUE_THIRD      = 10'(255 / 3);
  localparam logic [9:0] HUE_TWO_THIRDS = 10'(2 * 255 / 3);
  localparam logic [9:0] HUE_WRAP       = 10'd255;
  // x/6 == (x*171) >> 10 for every 8-bit x
  localparam logic [7:0] RECIP_SIX      = 8'd171;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [1:0]                     sel;
    logic                           grey;
    logic [7:0]                     mx;
    logic [7:0]                     delta;
    logic [NUM_LANES-1:0][7:0]      rem;
    logic [NUM_LANES-1:0][7:0]      quo;
  } div_t;

endpackage

// ===== rtl/rhsv_front.sv =====
module rhsv_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  rhsv_pkg::pix_t up_pix,
  output logic           dn_valid,
  input  logic           dn_ready,
  output rhsv_pkg::div_t dn_data
);

  logic           valid_r;
  rhsv_pkg::div_t data_r;
  rhsv_pkg::div_t data_nxt;
  logic [7:0]     mx;
  logic [7:0]     mn;
  logic [7:0]     delta;
  logic [1:0]     sel;
  logic [15:0]    prod_r;
  logic [15:0]    prod_g;
  logic [15:0]    prod_b;

  always_comb begin
    if (up_pix.red >= up_pix.green && up_pix.red >= up_pix.blue) begin
      sel = rhsv_pkg::SEL_RED;
      mx  = up_pix.red;
    end else if (up_pix.green >= up_pix.blue) begin
      sel = rhsv_pkg::SEL_GREEN;
      mx  = up_pix.green;
    end else begin
      sel = rhsv_pkg::SEL_BLUE;
      mx  = up_pix.blue;
    end
    mn = up_pix.red;
    if (up_pix.green < mn) mn = up_pix.green;
    if (up_pix.blue < mn) mn = up_pix.blue;
    delta  = mx - mn;
    prod_r = {8'd0, mx - up_pix.red}   * {8'd0, rhsv_pkg::RECIP_SIX};
    prod_g = {8'd0, mx - up_pix.green} * {8'd0, rhsv_pkg::RECIP_SIX};
    prod_b = {8'd0, mx - up_pix.blue}  * {8'd0, rhsv_pkg::RECIP_SIX};
    data_nxt.sel   = sel;
    data_nxt.grey  = (delta == 8'd0);
    data_nxt.mx    = mx;
    data_nxt.delta = delta;
    data_nxt.quo   = '0;
    data_nxt.rem[rhsv_pkg::LANE_SAT] = delta;
    data_nxt.rem[rhsv_pkg::LANE_R]   = {2'd0, prod_r[15:10]} + {1'b0, delta[7:1]};
    data_nxt.rem[rhsv_pkg::LANE_G]   = {2'd0, prod_g[15:10]} + {1'b0, delta[7:1]};
    data_nxt.rem[rhsv_pkg::LANE_B]   = {2'd0, prod_b[15:10]} + {1'b0, delta[7:1]};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/rhsv_cell.sv =====
module rhsv_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  rhsv_pkg::div_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output rhsv_pkg::div_t dn_data
);

  logic           valid_r;
  rhsv_pkg::div_t data_r;
  rhsv_pkg::div_t data_nxt;
  logic [8:0]     dbl;
  logic [8:0]     dvs;

  // one restoring step per lane: shift, compare, subtract
  always_comb begin
    data_nxt = up_data;
    dbl      = '0;
    dvs      = '0;
    for (int i = 0; i < rhsv_pkg::NUM_LANES; i++) begin
      dbl = {up_data.rem[i], 1'b0};
      dvs = (i == rhsv_pkg::LANE_SAT) ? {1'b0, up_data.mx} : {1'b0, up_data.delta};
      if (dbl >= dvs) begin
        data_nxt.rem[i] = 8'(dbl - dvs);
        data_nxt.quo[i] = {up_data.quo[i][6:0], 1'b1};
      end else begin
        data_nxt.rem[i] = dbl[7:0];
        data_nxt.quo[i] = {up_data.quo[i][6:0], 1'b0};
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/rhsv_back.sv =====
module rhsv_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  rhsv_pkg::div_t up_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rhsv_pkg::hsv_t out_hsv
);

  logic           valid_r;
  rhsv_pkg::hsv_t hsv_r;
  rhsv_pkg::hsv_t hsv_nxt;
  logic [9:0]     tr;
  logic [9:0]     tg;
  logic [9:0]     tb;
  logic [9:0]     h;
  logic [9:0]     hw;

  always_comb begin
    tr = {2'd0, up_data.quo[rhsv_pkg::LANE_R]};
    tg = {2'd0, up_data.quo[rhsv_pkg::LANE_G]};
    tb = {2'd0, up_data.quo[rhsv_pkg::LANE_B]};
    case (up_data.sel)
      rhsv_pkg::SEL_RED:   h = tb - tg;
      rhsv_pkg::SEL_GREEN: h = rhsv_pkg::HUE_THIRD + tr - tb;
      default:             h = rhsv_pkg::HUE_TWO_THIRDS + tg - tr;
    endcase
    // signed hue spans -255..425
    if ($signed(h) < 0) begin
      hw = h + rhsv_pkg::HUE_WRAP;
    end else if ($signed(h) > $signed(10'd255)) begin
      hw = h - rhsv_pkg::HUE_WRAP;
    end else begin
      hw = h;
    end
    hsv_nxt.brightness = up_data.mx;
    hsv_nxt.hue        = up_data.grey ? 8'd0 : hw[7:0];
    hsv_nxt.saturation = up_data.grey ? 8'd0 : up_data.quo[rhsv_pkg::LANE_SAT];
  end

  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      hsv_r <= hsv_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_hsv   = hsv_r;

endmodule

// ===== rtl/rgb_to_hsv_8bit.sv =====
// RGB to HSV converter, 8 bits a channel. One pixel transaction in, one out,
// no kept state. Throughput is one pixel per clock while out_stall is low;
// the stages are a min/max and numerator stage, a chain of 8 divider cells
// (one quotient bit each, four division lanes side by side), and an output
// register that forms the hue. Each stage holds its own valid bit and
// advances whenever the next stage is empty or moving, so bubbles collapse
// and new pixels are taken while a finished result is held by out_stall;
// in_stall rises only when every stage is full and the output is stalled.
// Brightness is max(r,g,b). A grey pixel gives hue and saturation of zero.
// Saturation is delta*256/max, clamped to 255. Hue uses 85/170 offsets for
// green/blue maximum, ties prefer red then green, wrapped into 0..255.
module rgb_to_hsv_8bit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rhsv_pkg::pix_t in_pix,
  output logic           out_valid,
  input  logic           out_stall,
  output rhsv_pkg::hsv_t out_hsv
);

  logic                 valid_c [rhsv_pkg::NUM_CELLS+1];
  logic                 ready_c [rhsv_pkg::NUM_CELLS+1];
  rhsv_pkg::div_t       data_c  [rhsv_pkg::NUM_CELLS+1];
  logic                 in_ready;

  // front stage: max/min, delta, per-channel numerators
  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_pix   (in_pix),
    .dn_valid (valid_c[0]),
    .dn_ready (ready_c[0]),
    .dn_data  (data_c[0])
  );

  assign in_stall = !in_ready;

  // divider chain
  for (genvar i = 0; i < rhsv_pkg::NUM_CELLS; i++) begin : g_cell
    rhsv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_c[i]),
      .up_ready (ready_c[i]),
      .up_data  (data_c[i]),
      .dn_valid (valid_c[i+1]),
      .dn_ready (ready_c[i+1]),
      .dn_data  (data_c[i+1])
    );
  end

  // hue select, wrap and output register
  rhsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (valid_c[rhsv_pkg::NUM_CELLS]),
    .up_ready  (ready_c[rhsv_pkg::NUM_CELLS]),
    .up_data   (data_c[rhsv_pkg::NUM_CELLS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hsv   (out_hsv)
  );

`ifndef ASSERT_OFF
  // zero saturation only happens for grey, which has zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hsv.saturation == 8'd0 |-> out_hsv.hue == 8'd0)
    else $error("nonzero hue on grey pixel");

  // input only stalls when the output holds a result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in pipeline");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

  // brightness is never below saturation-free minimum: nonzero sat needs nonzero value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hsv.brightness == 8'd0 |-> out_hsv.saturation == 8'd0)
    else $error("saturation on black pixel");
`endif

endmodule
